// File: rtl/core/dfsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfsr_pkg;

   // PWM duty width; duty outputs carry the low eight bits
   localparam int DUTY_BITS = 8;

   localparam int FUNC_BITS  = 3;
   localparam int TIME_BITS  = 32;
   localparam int SPEED_BITS = 13;
   localparam int GOAL_BITS  = 12;
   localparam int BYTE_BITS  = 8;
   localparam int KIND_BITS  = 2;
   localparam int THR_BITS   = 16;
   localparam int SCALE_BITS = 4;
   localparam int CSR_BITS   = 16;

   // request function codes
   localparam logic [FUNC_BITS-1:0] FN_FAN1_EDGE = 3'd0;
   localparam logic [FUNC_BITS-1:0] FN_FAN2_EDGE = 3'd1;
   localparam logic [FUNC_BITS-1:0] FN_TICK      = 3'd2;
   localparam logic [FUNC_BITS-1:0] FN_BUS_WRITE = 3'd3;
   localparam logic [FUNC_BITS-1:0] FN_BUS_READ  = 3'd4;

   // bus module bytes
   localparam logic [BYTE_BITS-1:0] MOD_FAN1 = 8'h12;
   localparam logic [BYTE_BITS-1:0] MOD_FAN2 = 8'h13;
   localparam logic [BYTE_BITS-1:0] MOD_BOTH = 8'h14;

   // reply kinds
   localparam logic [KIND_BITS-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_RPM     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 2'd2;

   // CSR indexes
   localparam logic CSR_DEBOUNCE = 1'b0;
   localparam logic CSR_SCALE    = 1'b1;

   localparam logic [THR_BITS-1:0]   DEBOUNCE_RESET = 16'd5000;
   localparam logic [SCALE_BITS-1:0] SCALE_RESET    = 4'd8;

   // rpm = 30e6 / gap, numerator fits in 25 bits
   localparam int DIV_BITS = 25;
   localparam int CNT_BITS = 5;
   localparam logic [DIV_BITS-1:0]   RPM_NUMERATOR = 25'd30000000;
   localparam logic [SPEED_BITS-1:0] SPEED_MAX     = 13'd8191;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD
   } dfsr_state_type;

   typedef struct packed {
      logic take;   // request accepted this cycle
      logic step;   // one divider iteration
      logic load;   // move result into the output register
   } dfsr_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } dfsr_status_type;

endpackage

`default_nettype wire

// File: rtl/core/dual_fan_tach_speed_regulator_unit.sv
// Two-fan tachometer speed regulator.
// Request channel (req_valid / req_stall): func selects a tach edge for fan 1
// or fan 2, a control tick, a bus write or a bus read; the other fields carry
// the edge time stamp and the bus module, data byte and data flag.
// Response channel (rsp_valid / rsp_stall): one response per request with both
// duties after the request and, for a bus read, the rpm reply and its kind.
// CSR port: csr_write_en with csr_index 0 (debounce threshold, us) or 1
// (goal scale); write only while no request is in flight.
// Flow: an accepted request is registered, then moved in ST_LOAD into the output
// register that drives rsp_valid. A tach edge whose gap passes the debounce
// threshold first runs a bit-serial restoring divider (one quotient bit per cycle
// over 25 bits) in ST_DIV. One request is in flight at a time: the next one is
// taken only after the last has moved into the output register.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the response holds and the next finished
// request waits in the block with req_stall high.
// Reset (synchronous) clears speeds, goals, duties, edge times and the
// selected module, and loads threshold 5000 and scale 8.
`timescale 1ns / 1ps
`default_nettype none

module dual_fan_tach_speed_regulator_unit import dfsr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic                  csr_index,
   input  wire logic [CSR_BITS-1:0]   csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [TIME_BITS-1:0]  req_timestamp_us,
   input  wire logic [BYTE_BITS-1:0]  req_module_id,
   input  wire logic [BYTE_BITS-1:0]  req_write_data,
   input  wire logic                  req_has_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [BYTE_BITS-1:0]       rsp_duty_fan1,
   output logic [BYTE_BITS-1:0]       rsp_duty_fan2,
   output logic [SPEED_BITS-1:0]      rsp_reply_first,
   output logic [SPEED_BITS-1:0]      rsp_reply_second,
   output logic [KIND_BITS-1:0]       rsp_reply_kind
);

   dfsr_cmd_type    cmd;
   dfsr_status_type status;

   dfsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dfsr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_func         (req_func),
      .req_timestamp_us (req_timestamp_us),
      .req_module_id    (req_module_id),
      .req_write_data   (req_write_data),
      .req_has_data     (req_has_data),
      .rsp_duty_fan1    (rsp_duty_fan1),
      .rsp_duty_fan2    (rsp_duty_fan2),
      .rsp_reply_first  (rsp_reply_first),
      .rsp_reply_second (rsp_reply_second),
      .rsp_reply_kind   (rsp_reply_kind)
   );

endmodule

`default_nettype wire

// File: rtl/core/dfsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dfsr_ctrl import dfsr_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire dfsr_status_type status,
   output dfsr_cmd_type         cmd
);

   dfsr_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.need_div ? ST_DIV : ST_LOAD;
            end
         end
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.take = req_valid;
         ST_DIV:  cmd.step = 1'b1;
         ST_LOAD: cmd.load = slot_free;
         default: cmd = '0;
      endcase
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/dfsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dfsr_dp import dfsr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dfsr_cmd_type          cmd,
   output dfsr_status_type            status,
   input  wire logic                  csr_write_en,
   input  wire logic                  csr_index,
   input  wire logic [CSR_BITS-1:0]   csr_wdata,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [TIME_BITS-1:0]  req_timestamp_us,
   input  wire logic [BYTE_BITS-1:0]  req_module_id,
   input  wire logic [BYTE_BITS-1:0]  req_write_data,
   input  wire logic                  req_has_data,
   output logic [BYTE_BITS-1:0]       rsp_duty_fan1,
   output logic [BYTE_BITS-1:0]       rsp_duty_fan2,
   output logic [SPEED_BITS-1:0]      rsp_reply_first,
   output logic [SPEED_BITS-1:0]      rsp_reply_second,
   output logic [KIND_BITS-1:0]       rsp_reply_kind
);

   localparam logic [15:0] DUTY_MAX_W = 16'((32'd1 << DUTY_BITS) - 32'd1);

   // configuration
   logic [THR_BITS-1:0]   thr_ff, thr_in;
   logic [SCALE_BITS-1:0] scale_ff, scale_in;

   // block state
   logic [TIME_BITS-1:0]  last1_ff, last1_in, last2_ff, last2_in;
   logic [SPEED_BITS-1:0] speed1_ff, speed1_in, speed2_ff, speed2_in;
   logic [GOAL_BITS-1:0]  goal1_ff, goal1_in, goal2_ff, goal2_in;
   logic [DUTY_BITS-1:0]  duty1_ff, duty1_in, duty2_ff, duty2_in;
   logic [BYTE_BITS-1:0]  sel_ff, sel_in;

   // reply held until the output register is free
   logic [SPEED_BITS-1:0] first_ff, first_in, second_ff, second_in;
   logic [KIND_BITS-1:0]  kind_ff, kind_in;

   // divider
   logic [TIME_BITS-1:0]  gap_ff, gap_in;
   logic [TIME_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]   dvd_ff, dvd_in, quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  fan2_ff, fan2_in;

   // output register
   logic [BYTE_BITS-1:0]  o_duty1_ff, o_duty1_in, o_duty2_ff, o_duty2_in;
   logic [SPEED_BITS-1:0] o_first_ff, o_first_in, o_second_ff, o_second_in;
   logic [KIND_BITS-1:0]  o_kind_ff, o_kind_in;

   logic [TIME_BITS-1:0]  edge_time, gap;
   logic                  is_edge, gap_ok;
   logic [TIME_BITS:0]    trial, diff;
   logic                  fits;
   logic [DIV_BITS-1:0]   quo_next;
   logic [SPEED_BITS-1:0] speed_new;
   logic                  known;
   logic [GOAL_BITS-1:0]  goal_new;
   logic [15:0]           data_w, duty_w;
   logic                  up1, dn1, up2, dn2;

   assign is_edge   = (req_func == FN_FAN1_EDGE) || (req_func == FN_FAN2_EDGE);
   assign edge_time = (req_func == FN_FAN2_EDGE) ? last2_ff : last1_ff;
   assign gap       = req_timestamp_us - edge_time;
   assign gap_ok    = gap > {16'd0, thr_ff};

   assign status.need_div = is_edge && gap_ok;
   assign status.div_last = (cnt_ff == '0);

   // restoring division, one quotient bit per cycle
   assign trial     = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign diff      = trial - {1'b0, gap_ff};
   assign fits      = trial >= {1'b0, gap_ff};
   assign quo_next  = {quo_ff[DIV_BITS-2:0], fits};
   assign speed_new = (quo_next > DIV_BITS'(SPEED_MAX)) ? SPEED_MAX
                                                        : quo_next[SPEED_BITS-1:0];

   assign known    = (req_module_id == MOD_FAN1) || (req_module_id == MOD_FAN2) ||
                     (req_module_id == MOD_BOTH);
   assign goal_new = {4'd0, req_write_data} * {8'd0, scale_ff};
   assign data_w   = {8'd0, req_write_data};
   assign duty_w   = (data_w > DUTY_MAX_W) ? DUTY_MAX_W : data_w;

   assign up1 = (speed1_ff < SPEED_BITS'(goal1_ff)) && (duty1_ff != '1);
   assign dn1 = (speed1_ff > SPEED_BITS'(goal1_ff)) && (duty1_ff != '0);
   assign up2 = (speed2_ff < SPEED_BITS'(goal2_ff)) && (duty2_ff != '1);
   assign dn2 = (speed2_ff > SPEED_BITS'(goal2_ff)) && (duty2_ff != '0);

   always_comb begin
      thr_in      = thr_ff;
      scale_in    = scale_ff;
      last1_in    = last1_ff;
      last2_in    = last2_ff;
      speed1_in   = speed1_ff;
      speed2_in   = speed2_ff;
      goal1_in    = goal1_ff;
      goal2_in    = goal2_ff;
      duty1_in    = duty1_ff;
      duty2_in    = duty2_ff;
      sel_in      = sel_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      kind_in     = kind_ff;
      gap_in      = gap_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      fan2_in     = fan2_ff;
      o_duty1_in  = o_duty1_ff;
      o_duty2_in  = o_duty2_ff;
      o_first_in  = o_first_ff;
      o_second_in = o_second_ff;
      o_kind_in   = o_kind_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_DEBOUNCE: thr_in   = csr_wdata[THR_BITS-1:0];
            CSR_SCALE:    scale_in = csr_wdata[SCALE_BITS-1:0];
            default:      thr_in   = thr_ff;
         endcase
      end

      if (cmd.take) begin
         first_in  = '0;
         second_in = '0;
         kind_in   = KIND_NONE;
         gap_in    = gap;
         rem_in    = '0;
         dvd_in    = RPM_NUMERATOR;
         quo_in    = '0;
         cnt_in    = CNT_BITS'(DIV_BITS - 1);
         fan2_in   = (req_func == FN_FAN2_EDGE);
         case (req_func)
            FN_FAN1_EDGE: last1_in = req_timestamp_us;
            FN_FAN2_EDGE: last2_in = req_timestamp_us;
            FN_TICK: begin
               if (up1) duty1_in = duty1_ff + 1'b1;
               else if (dn1) duty1_in = duty1_ff - 1'b1;
               if (up2) duty2_in = duty2_ff + 1'b1;
               else if (dn2) duty2_in = duty2_ff - 1'b1;
            end
            FN_BUS_WRITE: begin
               sel_in = req_module_id;
               if (req_has_data && known) begin
                  goal1_in = goal_new;
                  goal2_in = goal_new;
                  duty1_in = duty_w[DUTY_BITS-1:0];
                  duty2_in = duty_w[DUTY_BITS-1:0];
               end
            end
            FN_BUS_READ: begin
               kind_in = KIND_RPM;
               if (sel_ff == MOD_FAN1) begin
                  first_in = speed1_ff;
               end else if (sel_ff == MOD_FAN2) begin
                  first_in = speed2_ff;
               end else if (sel_ff == MOD_BOTH) begin
                  first_in  = speed1_ff;
                  second_in = speed2_ff;
               end else begin
                  kind_in = KIND_UNKNOWN;
               end
            end
            default: kind_in = KIND_NONE;
         endcase
      end

      if (cmd.step) begin
         rem_in = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
         dvd_in = {dvd_ff[DIV_BITS-2:0], 1'b0};
         quo_in = quo_next;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            if (fan2_ff) speed2_in = speed_new;
            else speed1_in = speed_new;
         end
      end

      if (cmd.load) begin
         o_duty1_in  = BYTE_BITS'(16'(duty1_ff));
         o_duty2_in  = BYTE_BITS'(16'(duty2_ff));
         o_first_in  = first_ff;
         o_second_in = second_ff;
         o_kind_in   = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= DEBOUNCE_RESET;
         scale_ff  <= SCALE_RESET;
         last1_ff  <= '0;
         last2_ff  <= '0;
         speed1_ff <= '0;
         speed2_ff <= '0;
         goal1_ff  <= '0;
         goal2_ff  <= '0;
         duty1_ff  <= '0;
         duty2_ff  <= '0;
         sel_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         thr_ff    <= thr_in;
         scale_ff  <= scale_in;
         last1_ff  <= last1_in;
         last2_ff  <= last2_in;
         speed1_ff <= speed1_in;
         speed2_ff <= speed2_in;
         goal1_ff  <= goal1_in;
         goal2_ff  <= goal2_in;
         duty1_ff  <= duty1_in;
         duty2_ff  <= duty2_in;
         sel_ff    <= sel_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      second_ff   <= second_in;
      kind_ff     <= kind_in;
      gap_ff      <= gap_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      fan2_ff     <= fan2_in;
      o_duty1_ff  <= o_duty1_in;
      o_duty2_ff  <= o_duty2_in;
      o_first_ff  <= o_first_in;
      o_second_ff <= o_second_in;
      o_kind_ff   <= o_kind_in;
   end

   assign rsp_duty_fan1    = o_duty1_ff;
   assign rsp_duty_fan2    = o_duty2_ff;
   assign rsp_reply_first  = o_first_ff;
   assign rsp_reply_second = o_second_ff;
   assign rsp_reply_kind   = o_kind_ff;

endmodule

`default_nettype wire

// File: tb/sv/dfsr_checker.sv
`timescale 1ns / 1ps

module dfsr_checker import dfsr_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_en,
   input  wire logic                  csr_index,
   input  wire logic [CSR_BITS-1:0]   csr_wdata,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [FUNC_BITS-1:0]  req_func,
   input  wire logic [TIME_BITS-1:0]  req_timestamp_us,
   input  wire logic [BYTE_BITS-1:0]  req_module_id,
   input  wire logic [BYTE_BITS-1:0]  req_write_data,
   input  wire logic                  req_has_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic [BYTE_BITS-1:0]  rsp_duty_fan1,
   input  wire logic [BYTE_BITS-1:0]  rsp_duty_fan2,
   input  wire logic [SPEED_BITS-1:0] rsp_reply_first,
   input  wire logic [SPEED_BITS-1:0] rsp_reply_second,
   input  wire logic [KIND_BITS-1:0]  rsp_reply_kind,
   output int                         errors,
   output int                         waiting
);

   typedef struct packed {
      logic [BYTE_BITS-1:0]  duty1;
      logic [BYTE_BITS-1:0]  duty2;
      logic [SPEED_BITS-1:0] first;
      logic [SPEED_BITS-1:0] second;
      logic [KIND_BITS-1:0]  kind;
   } fan_reply_t;

   logic [THR_BITS-1:0]   debounce_us;
   logic [SCALE_BITS-1:0] goal_scale;
   logic [TIME_BITS-1:0]  prev_edge1, prev_edge2;
   logic [SPEED_BITS-1:0] rpm1, rpm2;
   logic [GOAL_BITS-1:0]  goal1, goal2;
   logic [DUTY_BITS-1:0]  pwm1, pwm2;
   logic [BYTE_BITS-1:0]  sel_mod;
   fan_reply_t            replies_due[$];

   // gap not above the threshold keeps the old speed (also avoids a zero divisor)
   function automatic logic [SPEED_BITS-1:0] edge_rpm(input logic [TIME_BITS-1:0] gap,
                                                      input logic [SPEED_BITS-1:0] old);
      logic [TIME_BITS-1:0] quot;
      if (gap <= debounce_us) return old;
      quot = {{(TIME_BITS-DIV_BITS){1'b0}}, RPM_NUMERATOR} / gap;
      return (quot > SPEED_MAX) ? SPEED_MAX : quot[SPEED_BITS-1:0];
   endfunction

   function automatic logic [DUTY_BITS-1:0] pwm_step(input logic [DUTY_BITS-1:0] d,
                                                     input logic [SPEED_BITS-1:0] s,
                                                     input logic [GOAL_BITS-1:0] g);
      if (s < {1'b0, g}) return (d == '1) ? d : d + 1'b1;
      if (s > {1'b0, g}) return (d == '0) ? d : d - 1'b1;
      return d;
   endfunction

   function automatic fan_reply_t apply_request(input logic [FUNC_BITS-1:0] f,
                                                input logic [TIME_BITS-1:0] ts,
                                                input logic [BYTE_BITS-1:0] mod,
                                                input logic [BYTE_BITS-1:0] data,
                                                input logic has);
      fan_reply_t r;
      logic [TIME_BITS-1:0] gap;
      logic [GOAL_BITS-1:0] g;
      r = '0;
      case (f)
         FN_FAN1_EDGE: begin
            gap = ts - prev_edge1;
            prev_edge1 = ts;
            rpm1 = edge_rpm(gap, rpm1);
         end
         FN_FAN2_EDGE: begin
            gap = ts - prev_edge2;
            prev_edge2 = ts;
            rpm2 = edge_rpm(gap, rpm2);
         end
         FN_TICK: begin
            pwm1 = pwm_step(pwm1, rpm1, goal1);
            pwm2 = pwm_step(pwm2, rpm2, goal2);
         end
         FN_BUS_WRITE: begin
            sel_mod = mod;
            if (has && (mod == MOD_FAN1 || mod == MOD_FAN2 || mod == MOD_BOTH)) begin
               g = {4'd0, data} * {8'd0, goal_scale};
               goal1 = g;
               goal2 = g;
               pwm1 = data;
               pwm2 = data;
            end
         end
         FN_BUS_READ: begin
            case (sel_mod)
               MOD_FAN1: begin
                  r.first = rpm1;
                  r.kind = KIND_RPM;
               end
               MOD_FAN2: begin
                  r.first = rpm2;
                  r.kind = KIND_RPM;
               end
               MOD_BOTH: begin
                  r.first = rpm1;
                  r.second = rpm2;
                  r.kind = KIND_RPM;
               end
               default: r.kind = KIND_UNKNOWN;
            endcase
         end
         default: ;
      endcase
      r.duty1 = pwm1[BYTE_BITS-1:0];
      r.duty2 = pwm2[BYTE_BITS-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      fan_reply_t want, got;
      if (reset) begin
         debounce_us = DEBOUNCE_RESET;
         goal_scale = SCALE_RESET;
         prev_edge1 = '0;
         prev_edge2 = '0;
         rpm1 = '0;
         rpm2 = '0;
         goal1 = '0;
         goal2 = '0;
         pwm1 = '0;
         pwm2 = '0;
         sel_mod = '0;
         replies_due.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_DEBOUNCE) debounce_us = csr_wdata[THR_BITS-1:0];
            else goal_scale = csr_wdata[SCALE_BITS-1:0];
         end
         // response first: one can never answer a request taken on the same edge
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_duty_fan1, rsp_duty_fan2, rsp_reply_first, rsp_reply_second,
                    rsp_reply_kind};
            if (replies_due.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = replies_due.pop_front();
               check_field("duty_fan1", want.duty1, got.duty1);
               check_field("duty_fan2", want.duty2, got.duty2);
               check_field("reply_first", want.first, got.first);
               check_field("reply_second", want.second, got.second);
               check_field("reply_kind", want.kind, got.kind);
            end
         end
         if (req_valid && !req_stall)
            replies_due.push_back(apply_request(req_func, req_timestamp_us, req_module_id,
                                                req_write_data, req_has_data));
      end
      waiting = replies_due.size();
   end

endmodule

// File: tb/sv/tb_dual_fan_tach_speed_regulator_unit.sv
`timescale 1ns / 1ps

module tb_dual_fan_tach_speed_regulator_unit import dfsr_pkg::*; ();

   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD   = 300;
   localparam logic [FUNC_BITS-1:0] FN_SPARE_LO = 3'd5;
   localparam logic [FUNC_BITS-1:0] FN_SPARE_HI = 3'd7;
   localparam logic [BYTE_BITS-1:0] MOD_STRAY   = 8'h55;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic                  csr_index;
   logic [CSR_BITS-1:0]   csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic [FUNC_BITS-1:0]  req_func;
   logic [TIME_BITS-1:0]  req_timestamp_us;
   logic [BYTE_BITS-1:0]  req_module_id;
   logic [BYTE_BITS-1:0]  req_write_data;
   logic                  req_has_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BYTE_BITS-1:0]  rsp_duty_fan1;
   logic [BYTE_BITS-1:0]  rsp_duty_fan2;
   logic [SPEED_BITS-1:0] rsp_reply_first;
   logic [SPEED_BITS-1:0] rsp_reply_second;
   logic [KIND_BITS-1:0]  rsp_reply_kind;

   int                    fail_count;
   int                    pending;
   bit                    random_on = 1'b0;
   int                    burst_left = 0;
   int unsigned           cur_thr = DEBOUNCE_RESET;
   logic [TIME_BITS-1:0]  fan1_time = '0;
   logic [TIME_BITS-1:0]  fan2_time = '0;

   always #4 clock = ~clock;

   dual_fan_tach_speed_regulator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_timestamp_us (req_timestamp_us),
      .req_module_id    (req_module_id),
      .req_write_data   (req_write_data),
      .req_has_data     (req_has_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duty_fan1    (rsp_duty_fan1),
      .rsp_duty_fan2    (rsp_duty_fan2),
      .rsp_reply_first  (rsp_reply_first),
      .rsp_reply_second (rsp_reply_second),
      .rsp_reply_kind   (rsp_reply_kind)
   );

   dfsr_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_timestamp_us (req_timestamp_us),
      .req_module_id    (req_module_id),
      .req_write_data   (req_write_data),
      .req_has_data     (req_has_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_duty_fan1    (rsp_duty_fan1),
      .rsp_duty_fan2    (rsp_duty_fan2),
      .rsp_reply_first  (rsp_reply_first),
      .rsp_reply_second (rsp_reply_second),
      .rsp_reply_kind   (rsp_reply_kind),
      .errors           (fail_count),
      .waiting          (pending)
   );

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // receiver: random stall pattern in runs, plus one long hold once random traffic starts
   initial begin : receiver
      int run_left, mode;
      bit long_done;
      run_left = 0;
      mode = 0;
      long_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (random_on && !long_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            long_done = 1'b1;
         end
         if (run_left == 0) begin
            mode = $urandom_range(0, 3);
            run_left = $urandom_range(4, 60);
         end
         run_left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // entered and left on a falling edge; bursts of requests with random gaps
   task automatic offer_request(input logic [FUNC_BITS-1:0] f, input logic [TIME_BITS-1:0] ts,
                                input logic [BYTE_BITS-1:0] mod,
                                input logic [BYTE_BITS-1:0] data, input logic has);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= f;
      req_timestamp_us <= ts;
      req_module_id <= mod;
      req_write_data <= data;
      req_has_data <= has;
      if (f == FN_FAN1_EDGE) fan1_time = ts;
      if (f == FN_FAN2_EDGE) fan2_time = ts;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_regs(input logic [THR_BITS-1:0] thr, input logic [SCALE_BITS-1:0] scale);
      csr_write_en <= 1'b1;
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= thr;
      @(negedge clock);
      csr_index <= CSR_SCALE;
      csr_wdata <= {{(CSR_BITS-SCALE_BITS){1'b0}}, scale};
      @(negedge clock);
      csr_write_en <= 1'b0;
      cur_thr = thr;
   endtask

   function automatic logic [TIME_BITS-1:0] edge_time(input logic [TIME_BITS-1:0] prev);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return prev + $urandom_range(0, cur_thr);  // bounce
         2: return prev + cur_thr + $urandom_range(0, 2);
         default: return prev + $urandom_range(3600, 70000);
      endcase
   endfunction

   task automatic random_request();
      int pick;
      logic [FUNC_BITS-1:0] f;
      logic [TIME_BITS-1:0] ts;
      logic [BYTE_BITS-1:0] mod, data;
      logic has;
      pick = $urandom_range(0, 99);
      ts = $urandom;
      mod = 8'($urandom);
      data = 8'($urandom);
      has = 1'($urandom);
      if (pick < 20) f = FN_FAN1_EDGE;
      else if (pick < 40) f = FN_FAN2_EDGE;
      else if (pick < 62) f = FN_TICK;
      else if (pick < 80) f = FN_BUS_WRITE;
      else if (pick < 95) f = FN_BUS_READ;
      else f = FUNC_BITS'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      if (f == FN_FAN1_EDGE) ts = edge_time(fan1_time);
      if (f == FN_FAN2_EDGE) ts = edge_time(fan2_time);
      if (f == FN_BUS_WRITE) begin
         case ($urandom_range(0, 6))
            0, 1: mod = MOD_FAN1;
            2, 3: mod = MOD_FAN2;
            4, 5: mod = MOD_BOTH;
            default: ;
         endcase
         has = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 7))
            0: data = '0;
            1: data = '1;
            default: ;
         endcase
      end
      offer_request(f, ts, mod, data, has);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_DEBOUNCE;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_func = FN_TICK;
      req_timestamp_us = '0;
      req_module_id = '0;
      req_write_data = '0;
      req_has_data = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: threshold 5000, scale 8
      // nothing selected
      offer_request(FN_BUS_READ, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_WRITE, $urandom, MOD_BOTH, 8'hFF, 1'b1);
      // duty pinned at top
      offer_request(FN_TICK, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_FAN1_EDGE, 32'd3000, 8'($urandom), 8'($urandom), 1'($urandom));
      // gap equals threshold
      offer_request(FN_FAN1_EDGE, 32'd8000, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_FAN1_EDGE, 32'd13001, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_FAN2_EDGE, 32'hFFFF_FFFF, 8'($urandom), 8'($urandom), 1'($urandom));
      // wraps
      offer_request(FN_FAN2_EDGE, 32'd5999, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_READ, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_WRITE, $urandom, MOD_FAN1, 8'hA5, 1'b0);        // select only
      offer_request(FN_BUS_READ, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_WRITE, $urandom, MOD_FAN2, 8'h00, 1'b1);
      // duty pinned at zero
      offer_request(FN_TICK, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_READ, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_WRITE, $urandom, MOD_STRAY, 8'd200, 1'b1);
      offer_request(FN_BUS_READ, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      for (int c = FN_SPARE_LO; c <= FN_SPARE_HI; c++)
         offer_request(FUNC_BITS'(c), $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_WRITE, $urandom, MOD_FAN1, 8'd100, 1'b1);
      offer_request(FN_TICK, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      drain_block();

      // no debounce, widest scale: saturated speeds and a zero gap
      set_regs('0, 4'd15);
      offer_request(FN_FAN1_EDGE, 32'd13002, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_FAN1_EDGE, 32'd13002, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_FAN1_EDGE, 32'd16664, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_FAN1_EDGE, 32'd20327, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_BUS_WRITE, $urandom, MOD_BOTH, 8'hFF, 1'b1);
      offer_request(FN_BUS_READ, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      drain_block();

      // zero scale and the largest threshold
      set_regs('1, 4'd0);
      offer_request(FN_BUS_WRITE, $urandom, MOD_BOTH, 8'd77, 1'b1);
      offer_request(FN_TICK, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      offer_request(FN_FAN2_EDGE, 32'd5999 + 32'd65535, 8'($urandom), 8'($urandom),
                    1'($urandom));
      offer_request(FN_FAN2_EDGE, 32'd5999 + 32'd131071, 8'($urandom), 8'($urandom),
                    1'($urandom));
      offer_request(FN_BUS_READ, $urandom, 8'($urandom), 8'($urandom), 1'($urandom));
      drain_block();

      random_on = 1'b1;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_regs(16'($urandom_range(0, 65535)), 4'($urandom_range(1, 15)));
            1: set_regs('0, 4'd1);
            2: set_regs('1, 4'd15);
            3: set_regs(DEBOUNCE_RESET, SCALE_RESET);
            default: set_regs(16'($urandom_range(0, 65535)), 4'($urandom_range(1, 15)));
         endcase
         repeat (140) random_request();
         drain_block();
      end

      repeat (30) @(negedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
